/* hdl/c5vs_pkg.sv */
// shared types and constants of the 5x5 streaming convolution
`default_nettype none

package c5vs_pkg;

    localparam int TAPS        = 5;
    localparam int LINES       = TAPS - 1;
    localparam int LANE_W      = 2;
    localparam int COEF_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;
    localparam int IMG_W       = 11;
    localparam int POS_OUT_W   = 10;
    localparam int RESULT_W    = 36;
    localparam int WIDTH_LIMIT = 1024;
    localparam int WIDTH_MIN   = 5;
    localparam int WIDTH_RESET = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW4   = 3'd5;

    typedef struct packed {
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 last;
    } c5vs_meta_t;

endpackage

`default_nettype wire

/* hdl/conv5x5_valid_stream.sv */
// 5x5 valid-window convolution over a raster pixel stream with a shared line store
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | sink      | in_valid / in_stall    | pixel, frame_start
//  out     | source    | out_valid / out_stall  | filtered_value, out_row, out_col,
//          |           |                        | frame_last
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one pixel per cycle while in_stall is low; the line store takes one read and one lane write per pixel
//  each pixel transaction reaches its result through fetch, window, products,
//  row sums and the output register
//  reset clears control, position, window and configuration; the line store has no
//  clearing pass and needs none, since rows below 4 never reach a result
//  each stage fills a bubble on its own; in_stall rises only when all five stages
//  hold a transaction and out_stall is high
`default_nettype none

module conv5x5_valid_stream
    import c5vs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [15:0]                  pixel,
    input  wire logic                         frame_start,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [RESULT_W-1:0]        filtered_value,
    output logic [POS_OUT_W-1:0]              out_row,
    output logic [POS_OUT_W-1:0]              out_col,
    output logic                              frame_last,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int WIDTH_CAP = (MAX_WIDTH < WIDTH_LIMIT) ? MAX_WIDTH : WIDTH_LIMIT;
    localparam int POS_W     = $clog2(WIDTH_CAP);
    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int PROD_W    = PIXEL_BITS + 1 + COEF_W;
    localparam int RSUM_W    = PROD_W + 3;

    // configuration
    logic [IMG_W-1:0]                 image_width_reg;
    logic [TAPS-1:0][CFG_DATA_W-1:0]  coef_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMG_W'(WIDTH_RESET);
            coef_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index) inside
                CFG_IMAGE_WIDTH:
                begin
                    image_width_reg <= cfg_data[IMG_W-1:0];
                end
                [CFG_COEF_ROW0:CFG_COEF_ROW4]:
                begin
                    coef_reg[CFG_IDX_W'(cfg_index - CFG_COEF_ROW0)] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // flow control
    logic s1_valid_reg, win_valid_reg, pr_valid_reg, rs_valid_reg, out_valid_reg;
    logic s1_free, win_free, pr_free, rs_free, out_free;
    logic accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign rs_free  = !rs_valid_reg || out_free;
    assign pr_free  = !pr_valid_reg || rs_free;
    assign win_free = !win_valid_reg || pr_free;
    assign s1_free  = !s1_valid_reg || win_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    // position
    logic [POS_W-1:0] row_pos_reg, col_pos_reg;
    logic [POS_W-1:0] row_pos_next, col_pos_next;
    logic [POS_W-1:0] row_eff, col_eff;
    logic [IMG_W-1:0] width_eff;
    logic             restart;
    logic [IMG_W-1:0] col_inc, row_inc;
    logic             produce;
    c5vs_meta_t       meta_now;

    always_comb
    begin
        if (image_width_reg < IMG_W'(WIDTH_MIN))
            width_eff = IMG_W'(WIDTH_MIN);
        else if (image_width_reg > IMG_W'(WIDTH_CAP))
            width_eff = IMG_W'(WIDTH_CAP);
        else
            width_eff = image_width_reg;

        restart = frame_start || (IMG_W'(row_pos_reg) >= width_eff)
                  || (IMG_W'(col_pos_reg) >= width_eff);
        row_eff = restart ? '0 : row_pos_reg;
        col_eff = restart ? '0 : col_pos_reg;

        col_inc = IMG_W'(col_eff) + IMG_W'(1);
        row_inc = IMG_W'(row_eff) + IMG_W'(1);
        if (col_inc >= width_eff)
        begin
            col_pos_next = '0;
            row_pos_next = (row_inc >= width_eff) ? '0 : POS_W'(row_inc);
        end
        else
        begin
            col_pos_next = POS_W'(col_inc);
            row_pos_next = row_eff;
        end

        produce = (row_eff >= POS_W'(LINES)) && (col_eff >= POS_W'(LINES));
        meta_now.row  = POS_OUT_W'(row_eff - POS_W'(LINES));
        meta_now.col  = POS_OUT_W'(col_eff - POS_W'(LINES));
        meta_now.last = (IMG_W'(row_eff) == width_eff - IMG_W'(1))
                        && (IMG_W'(col_eff) == width_eff - IMG_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

    // line store: one entry per column, one lane per stored line
    logic [LINES-1:0][PIXEL_BITS-1:0] line_mem [MAX_WIDTH];
    logic [LINES-1:0][PIXEL_BITS-1:0] line_rd_reg;
    logic [AW-1:0]                    mem_addr;
    logic [LANE_W-1:0]                wr_lane;

    assign mem_addr = AW'(col_eff);
    assign wr_lane  = row_eff[LANE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_rd_reg                 <= line_mem[mem_addr];
            line_mem[mem_addr][wr_lane] <= pixel[PIXEL_BITS-1:0];
        end
    end

    // fetch stage
    logic                  s1_prod_reg;
    c5vs_meta_t            s1_meta_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [LANE_W-1:0]     s1_rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prod_reg <= produce;
            s1_meta_reg <= meta_now;
            s1_px_reg   <= pixel[PIXEL_BITS-1:0];
            s1_rot_reg  <= wr_lane;
        end
    end

    // window stage
    logic [TAPS-1:0][TAPS-1:0][PIXEL_BITS-1:0] win_reg;
    logic [TAPS-1:0][PIXEL_BITS-1:0]           new_col;
    c5vs_meta_t                                win_meta_reg;
    logic                                      s1_adv;

    assign s1_adv = s1_valid_reg && win_free;

    always_comb
    begin
        for (int k = 0; k < LINES; k++)
            new_col[k] = line_rd_reg[s1_rot_reg + LANE_W'(k)];
        new_col[LINES] = s1_px_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            if (win_free)
                win_valid_reg <= s1_valid_reg && s1_prod_reg;
            if (s1_adv)
            begin
                for (int k = 0; k < TAPS; k++)
                begin
                    for (int l = 0; l < TAPS - 1; l++)
                        win_reg[k][l] <= win_reg[k][l+1];
                    win_reg[k][TAPS-1] <= new_col[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            win_meta_reg <= s1_meta_reg;
    end

    // product stage
    logic signed [PROD_W-1:0] prod_reg [TAPS][TAPS];
    c5vs_meta_t               pr_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_valid_reg <= 1'b0;
        else if (pr_free)
            pr_valid_reg <= win_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (win_valid_reg && pr_free)
        begin
            pr_meta_reg <= win_meta_reg;
            for (int k = 0; k < TAPS; k++)
                for (int l = 0; l < TAPS; l++)
                    prod_reg[k][l] <= $signed({1'b0, win_reg[k][l]})
                                      * $signed(coef_reg[k][l*COEF_W +: COEF_W]);
        end
    end

    // row sum stage
    logic signed [RSUM_W-1:0] rs_next [TAPS];
    logic signed [RSUM_W-1:0] rs_reg  [TAPS];
    c5vs_meta_t               rs_meta_reg;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            rs_next[k] = '0;
            for (int l = 0; l < TAPS; l++)
                rs_next[k] = rs_next[k] + RSUM_W'(prod_reg[k][l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rs_valid_reg <= 1'b0;
        else if (rs_free)
            rs_valid_reg <= pr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pr_valid_reg && rs_free)
        begin
            rs_meta_reg <= pr_meta_reg;
            for (int k = 0; k < TAPS; k++)
                rs_reg[k] <= rs_next[k];
        end
    end

    // output register
    logic signed [RESULT_W-1:0] total_next;
    logic signed [RESULT_W-1:0] total_reg;
    c5vs_meta_t                 out_meta_reg;

    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < TAPS; k++)
            total_next = total_next + RESULT_W'(rs_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= rs_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rs_valid_reg && out_free)
        begin
            total_reg    <= total_next;
            out_meta_reg <= rs_meta_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = total_reg;
    assign out_row        = out_meta_reg.row;
    assign out_col        = out_meta_reg.col;
    assign frame_last     = out_meta_reg.last;

    // checks
    a_accept_fills_fetch: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg
    ) else $error("accepted transaction missing from fetch stage");

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && win_valid_reg && pr_valid_reg
                      && rs_valid_reg && out_valid_reg)
    ) else $error("input stalled with a free stage");

    a_frame_start_no_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && frame_start) |=> !s1_prod_reg
    ) else $error("first pixel of a frame marked as producing a result");

    a_last_on_diagonal: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && frame_last) |-> (out_row == out_col)
    ) else $error("frame end flagged off the last window");

endmodule

`default_nettype wire

/* bench/conv5x5_valid_stream_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the 5x5 streaming convolution with a cycle-free predictor
module conv5x5_valid_stream_test;
    import c5vs_pkg::*;

    typedef struct packed
    {
        logic signed [RESULT_W-1:0] value;
        logic [POS_OUT_W-1:0]       row;
        logic [POS_OUT_W-1:0]       col;
        logic                       last;
    } conv_result_t;

    typedef struct packed
    {
        logic [15:0]  pixel;
        logic         start;
        logic         has_result;
        conv_result_t result;
    } burst_row_t;

    typedef struct packed
    {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [15:0]                 pixel = '0;
    logic                        frame_start = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [RESULT_W-1:0]  filtered_value;
    logic [POS_OUT_W-1:0]        out_row;
    logic [POS_OUT_W-1:0]        out_col;
    logic                        frame_last;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    // predictor copy of registers and storage
    logic [IMG_W-1:0]            width_shadow;
    logic [CFG_DATA_W-1:0]       coef_shadow [TAPS];
    logic [15:0]                 lane_shadow [LINES][WIDTH_LIMIT];
    logic [15:0]                 window_shadow [TAPS][TAPS];
    int unsigned                 row_at;
    int unsigned                 col_at;

    conv_result_t                results_due [$];
    reg_write_t                  pending_writes [$];
    burst_row_t                  burst [25];
    int unsigned                 mismatch_count = 0;
    int unsigned                 feed_mode = 0;
    int unsigned                 stall_mode = 0;
    int unsigned                 stall_left = 0;

    conv5x5_valid_stream dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel          (pixel),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .out_row        (out_row),
        .out_col        (out_col),
        .frame_last     (frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
        begin
            $display("MISMATCH %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap(input int unsigned mode);
        int unsigned r;
        r = $urandom_range(99);
        if (mode == 0)
            return 0;
        if (r < ((mode == 1) ? 75 : 45))
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] draw_pixel();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_coef_row();
        logic [CFG_DATA_W-1:0] v;
        v = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            case ($urandom_range(9))
                0: v[COEF_W*t +: COEF_W] = 12'h800;
                1: v[COEF_W*t +: COEF_W] = 12'h7FF;
                2: v[COEF_W*t +: COEF_W] = 12'h000;
                default: v[COEF_W*t +: COEF_W] = 12'($urandom);
            endcase
        end
        return v;
    endfunction

    function automatic int unsigned window_width();
        int unsigned w;
        w = width_shadow;
        if (w < WIDTH_MIN)
            w = WIDTH_MIN;
        if (w > WIDTH_LIMIT)
            w = WIDTH_LIMIT;
        return w;
    endfunction

    task automatic convolve_pixel(input logic [15:0] px, input logic start,
                                  output bit produced, output conv_result_t res);
        int unsigned             w;
        int unsigned             row;
        int unsigned             col;
        logic signed [63:0]      acc;
        logic signed [COEF_W-1:0] tap;
        w = window_width();
        produced = 1'b0;
        res = '0;
        if (start || row_at >= w || col_at >= w)
        begin
            row_at = 0;
            col_at = 0;
        end
        row = row_at;
        col = col_at;
        for (int k = 0; k < TAPS; k++)
            for (int l = 0; l < TAPS - 1; l++)
                window_shadow[k][l] = window_shadow[k][l+1];
        for (int k = 0; k < LINES; k++)
            window_shadow[k][TAPS-1] = lane_shadow[(row + k) % LINES][col];
        window_shadow[TAPS-1][TAPS-1] = px;
        lane_shadow[row % LINES][col] = px;
        if (row >= LINES && col >= LINES)
        begin
            acc = '0;
            for (int k = 0; k < TAPS; k++)
                for (int l = 0; l < TAPS; l++)
                begin
                    tap = coef_shadow[k][COEF_W*l +: COEF_W];
                    acc += longint'(window_shadow[k][l]) * longint'(tap);
                end
            res.value = acc[RESULT_W-1:0];
            res.row   = POS_OUT_W'(row - LINES);
            res.col   = POS_OUT_W'(col - LINES);
            res.last  = (row == w - 1) && (col == w - 1);
            produced  = 1'b1;
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= w)
                row = 0;
        end
        row_at = row;
        col_at = col;
    endtask

    task automatic push_pixel(input logic [15:0] px, input logic start,
                              input bit typed, input conv_result_t typed_res);
        int unsigned  gap;
        bit           produced;
        conv_result_t res;
        gap = pick_gap(feed_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel       <= px;
        frame_start <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        convolve_pixel(px, start, produced, res);
        if (typed)
            results_due.push_back(typed_res);
        else if (produced)
            results_due.push_back(res);
    endtask

    task automatic apply_settings();
        reg_write_t wr;
        while (pending_writes.size() != 0)
        begin
            wr = pending_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= wr.index;
            cfg_data  <= wr.data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (wr.index == CFG_IMAGE_WIDTH)
                width_shadow = wr.data[IMG_W-1:0];
            else if (wr.index >= CFG_COEF_ROW0 && wr.index <= CFG_COEF_ROW4)
                coef_shadow[wr.index - CFG_COEF_ROW0] = wr.data;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_block();
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // style 0: frame_start on each frame, 1: rely on wrap, 2: stray frame_start noise
    task automatic run_frames(input int unsigned n, input int unsigned style,
                              input bit force_start);
        logic start;
        for (int unsigned i = 0; i < n; i++)
        begin
            start = 1'b0;
            if (i == 0 && force_start)
                start = 1'b1;
            else if (style == 0 && row_at == 0 && col_at == 0)
                start = 1'b1;
            else if (style == 2 && $urandom_range(149) == 0)
                start = 1'b1;
            push_pixel(draw_pixel(), start, 1'b0, '0);
        end
        in_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        conv_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result row %0d col %0d", out_row, out_col));
            end
            else
            begin
                want = results_due.pop_front();
                if (filtered_value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d at row %0d col %0d",
                                              filtered_value, want.value, want.row, want.col));
                if (out_row !== want.row)
                    report_mismatch($sformatf("row %0d, expected %0d", out_row, want.row));
                if (out_col !== want.col)
                    report_mismatch($sformatf("col %0d, expected %0d at row %0d",
                                              out_col, want.col, want.row));
                if (frame_last !== want.last)
                    report_mismatch($sformatf("frame_last %0b, expected %0b at row %0d col %0d",
                                              frame_last, want.last, want.row, want.col));
            end
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap(stall_mode);
        end
    end

    initial
    begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned phase;
        int unsigned prev_aw;
        int unsigned aw;
        int unsigned wv;
        int unsigned n;
        int unsigned style;
        int unsigned r;
        bit          big_done;

        width_shadow = IMG_W'(WIDTH_RESET);
        row_at = 0;
        col_at = 0;
        for (int k = 0; k < TAPS; k++)
        begin
            coef_shadow[k] = '0;
            for (int l = 0; l < TAPS; l++)
                window_shadow[k][l] = '0;
        end
        for (int k = 0; k < LINES; k++)
            for (int c = 0; c < WIDTH_LIMIT; c++)
                lane_shadow[k][c] = '0;

        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full-scale frame at the clamped minimum width, every tap at -2048
        pending_writes.push_back('{CFG_IMAGE_WIDTH, CFG_DATA_W'(0)});
        for (int k = 0; k < TAPS; k++)
            pending_writes.push_back('{CFG_IDX_W'(CFG_COEF_ROW0 + k), 60'h800800800800800});
        pending_writes.push_back('{CFG_IDX_W'(CFG_COEF_ROW4 + 1), 60'h7FF7FF7FF7FF7FF});
        pending_writes.push_back('{CFG_IDX_W'(CFG_COEF_ROW4 + 2), CFG_DATA_W'(9)});
        apply_settings();
        for (int i = 0; i < 25; i++)
            burst[i] = '{16'hFFFF, i == 0, 1'b0, '0};
        burst[24].has_result = 1'b1;
        burst[24].result     = '{-36'sd3355392000, 10'd0, 10'd0, 1'b1};
        for (int i = 0; i < 25; i++)
            push_pixel(burst[i].pixel, burst[i].start, burst[i].has_result, burst[i].result);
        in_valid <= 1'b0;
        settle_block();

        sent = 0;
        phase = 0;
        big_done = 1'b0;
        while (sent < 1900)
        begin
            prev_aw = window_width();
            feed_mode = $urandom_range(2);
            stall_mode = $urandom_range(2);
            if (!big_done && sent >= 900)
            begin
                // widest image, one full row and a little more, wrapping into the next row
                pending_writes.push_back('{CFG_IMAGE_WIDTH, CFG_DATA_W'(2047)});
                apply_settings();
                n = WIDTH_LIMIT + $urandom_range(8, 40);
                run_frames(n, 1, 1'b1);
                settle_block();
                pending_writes.push_back('{CFG_IMAGE_WIDTH, CFG_DATA_W'(WIDTH_LIMIT)});
                apply_settings();
                run_frames(20, 1, 1'b0);
                settle_block();
                sent += n + 20;
                big_done = 1'b1;
                continue;
            end
            r = $urandom_range(99);
            if (phase == 0 || r < 80)
            begin
                r = $urandom_range(99);
                if (r < 15)
                    wv = $urandom_range(0, 4);
                else if (r < 75)
                    wv = $urandom_range(5, 12);
                else
                    wv = $urandom_range(13, 40);
                pending_writes.push_back('{CFG_IMAGE_WIDTH, CFG_DATA_W'(wv)});
            end
            for (int k = 0; k < TAPS; k++)
                if (phase == 0 || $urandom_range(1) == 1)
                    pending_writes.push_back('{CFG_IDX_W'(CFG_COEF_ROW0 + k), draw_coef_row()});
            if ($urandom_range(4) == 0)
                pending_writes.push_back('{CFG_IDX_W'(CFG_COEF_ROW4 + 1 + $urandom_range(1)),
                                           CFG_DATA_W'({$urandom, $urandom})});
            apply_settings();
            aw = window_width();
            style = $urandom_range(2);
            if (aw <= 12)
            begin
                if (style == 2)
                    n = $urandom_range(20, 3 * aw * aw);
                else
                    n = $urandom_range(1, 3) * aw * aw + $urandom_range(0, 2 * aw);
            end
            else
            begin
                n = $urandom_range(4 * aw + 10, 7 * aw);
            end
            // a wider image needs fresh line stores, so restart the frame
            run_frames(n, style, aw > prev_aw);
            settle_block();
            sent += n;
            phase++;
        end

        for (int c = 0; c < 50000 && results_due.size() != 0; c++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", results_due.size()));
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
